/* design/rbst_pkg.sv */
package rbst_pkg;

    localparam int COORD_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int T_BITS            = 64;
    localparam int DIST_BITS         = 32;
    localparam int AXES              = 3;
    localparam int CAP_BIT           = 62;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef logic signed [T_BITS-1:0] t_val_t;

    localparam t_val_t T_CAP   = t_val_t'((64'd1 << CAP_BIT) - 64'd1);
    localparam t_val_t T_LOWEST = {1'b1, {(T_BITS-1){1'b0}}};
    localparam t_val_t T_HIGHEST = {1'b0, {(T_BITS-1){1'b1}}};

    // one axis as seen by the merge stage
    typedef struct packed {
        t_val_t t_lo;
        t_val_t t_hi;
        logic   par;
        logic   in_slab;
        logic   dneg;
    } lane_res_t;

    typedef struct packed {
        logic                 hit;
        logic [DIST_BITS-1:0] distance;
        logic                 clipped;
        logic [1:0]           axis;
        logic                 pos;
    } hit_res_t;

endpackage

/* design/rbst_if.sv */
interface rbst_ray_if #(parameter int CW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] box_lo_x;
    logic signed [CW-1:0] box_lo_y;
    logic signed [CW-1:0] box_lo_z;
    logic signed [CW-1:0] box_hi_x;
    logic signed [CW-1:0] box_hi_y;
    logic signed [CW-1:0] box_hi_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
                  output ready);
endinterface

interface rbst_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] hit_distance;
    logic        distance_clipped;
    logic [1:0]  face_axis;
    logic        face_positive;

    modport source (output valid, hit, hit_distance, distance_clipped, face_axis,
                    face_positive, input ready);
    modport sink (input valid, hit, hit_distance, distance_clipped, face_axis,
                  face_positive, output ready);
endinterface

/* design/rbst_div.sv */
module rbst_div
    import rbst_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF,
    parameter int FW = FRACTION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                adv,
    input  logic signed [CW:0]  num,
    input  logic signed [CW-1:0] den,
    output t_val_t              q
);

    localparam int NB = CW + 1 + FW;
    localparam int RW = CW + 1;
    localparam int QX = (NB > T_BITS) ? NB : T_BITS;

    logic [RW-1:0] rem_reg [0:NB];
    logic [NB-1:0] nq_reg  [0:NB];
    logic [CW-1:0] ud_reg  [0:NB];
    logic          neg_reg [0:NB];
    t_val_t        q_reg;

    logic [CW:0]   un_in;
    logic [CW-1:0] ud_in;

    assign un_in = num[CW] ? (~num + 1'b1) : num;
    assign ud_in = den[CW-1] ? (~den + 1'b1) : den;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= {un_in, {FW{1'b0}}};
            ud_reg[0]  <= ud_in;
            neg_reg[0] <= num[CW] ^ den[CW-1];
        end
    end

    // one quotient bit per stage, restoring
    for (genvar s = 0; s < NB; s++)
    begin : g_stage
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = {rem_reg[s][RW-2:0], nq_reg[s][NB-1]};
        assign ge = (sh >= {1'b0, ud_reg[s]});
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= ge ? (sh - {1'b0, ud_reg[s]}) : sh;
                nq_reg[s+1]  <= {nq_reg[s][NB-2:0], ge};
                ud_reg[s+1]  <= ud_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    logic [QX-1:0] qx;
    logic          clamp;
    logic          rnz;
    t_val_t        mag;
    t_val_t        q_next;

    assign qx    = QX'(nq_reg[NB]);
    assign clamp = |qx[QX-1:CAP_BIT];
    assign rnz   = |rem_reg[NB];
    assign mag   = clamp ? T_CAP : t_val_t'(qx[T_BITS-1:0]);
    // floor for negative quotients: -mag - 1 is ~mag; a clamped value keeps -T_CAP
    assign q_next = neg_reg[NB] ? ((rnz && !clamp) ? ~mag : -mag) : mag;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* design/rbst_lane.sv */
module rbst_lane
    import rbst_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF,
    parameter int FW = FRACTION_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  logic signed [CW-1:0] origin,
    input  logic signed [CW-1:0] dir,
    input  logic signed [CW-1:0] lo,
    input  logic signed [CW-1:0] hi,
    output lane_res_t            res
);

    localparam int DL = CW + 1 + FW + 2;

    logic signed [CW:0]   dlo_reg;
    logic signed [CW:0]   dhi_reg;
    logic signed [CW-1:0] d_reg;
    logic [2:0]           sb_reg [0:DL];
    lane_res_t            res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dlo_reg   <= {lo[CW-1], lo} - {origin[CW-1], origin};
            dhi_reg   <= {hi[CW-1], hi} - {origin[CW-1], origin};
            d_reg     <= dir;
            sb_reg[0] <= {dir == '0, (origin >= lo) && (origin <= hi), dir[CW-1]};
        end
    end

    for (genvar s = 0; s < DL; s++)
    begin : g_sb
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sb_reg[s+1] <= sb_reg[s];
            end
        end
    end

    t_val_t t1;
    t_val_t t2;

    rbst_div #(.CW(CW), .FW(FW)) u_div_lo (
        .clk (clk), .adv (adv), .num (dlo_reg), .den (d_reg), .q (t1)
    );
    rbst_div #(.CW(CW), .FW(FW)) u_div_hi (
        .clk (clk), .adv (adv), .num (dhi_reg), .den (d_reg), .q (t2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if ($signed(t1) > $signed(t2))
            begin
                res_reg.t_lo <= t2;
                res_reg.t_hi <= t1;
            end
            else
            begin
                res_reg.t_lo <= t1;
                res_reg.t_hi <= t2;
            end
            res_reg.par     <= sb_reg[DL][2];
            res_reg.in_slab <= sb_reg[DL][1];
            res_reg.dneg    <= sb_reg[DL][0];
        end
    end

    assign res = res_reg;

endmodule

/* design/rbst_merge.sv */
module rbst_merge
    import rbst_pkg::*;
(
    input  logic                  clk,
    input  logic                  adv,
    input  lane_res_t [AXES-1:0]  lanes,
    output hit_res_t              res
);

    typedef struct packed {
        t_val_t     tmin;
        t_val_t     tmax;
        logic       miss;
        logic [1:0] axis;
        logic       pos;
    } fold_t;

    function automatic fold_t fold_step(fold_t f, lane_res_t l, logic [1:0] ax);
        fold_t  n;
        t_val_t nmin;
        t_val_t nmax;
        n    = f;
        nmin = ($signed(l.t_lo) > $signed(f.tmin)) ? l.t_lo : f.tmin;
        nmax = ($signed(l.t_hi) < $signed(f.tmax)) ? l.t_hi : f.tmax;
        if (!f.miss)
        begin
            if (l.par)
            begin
                n.miss = !l.in_slab;
            end
            else
            begin
                n.tmin = nmin;
                n.tmax = nmax;
                n.miss = $signed(nmin) > $signed(nmax);
                // equal entry values: later axis takes the face
                if ($signed(l.t_lo) >= $signed(f.tmin))
                begin
                    n.axis = ax;
                    n.pos  = l.dneg;
                end
            end
        end
        return n;
    endfunction

    fold_t     init;
    fold_t     f1_reg;
    fold_t     f2_reg;
    lane_res_t l1y_reg;
    lane_res_t l1z_reg;
    lane_res_t l2z_reg;
    hit_res_t  res_reg;
    fold_t     f3;
    hit_res_t  res_next;

    assign init = '{tmin: T_LOWEST, tmax: T_HIGHEST, miss: 1'b0, axis: AXIS_X, pos: 1'b0};
    assign f3   = fold_step(f2_reg, l2z_reg, AXIS_Z);

    always_comb
    begin
        res_next.hit      = !f3.miss && !f3.tmin[T_BITS-1];
        res_next.clipped  = res_next.hit && (|f3.tmin[T_BITS-2:DIST_BITS]);
        res_next.distance = !res_next.hit ? '0 :
                            (res_next.clipped ? '1 : f3.tmin[DIST_BITS-1:0]);
        res_next.axis     = res_next.hit ? f3.axis : AXIS_X;
        res_next.pos      = res_next.hit && f3.pos;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg  <= fold_step(init, lanes[0], AXIS_X);
            l1y_reg <= lanes[1];
            l1z_reg <= lanes[2];
            f2_reg  <= fold_step(f1_reg, l1y_reg, AXIS_Y);
            l2z_reg <= l1z_reg;
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* design/ray_box_slab_test.sv */
// Ray against axis-aligned box, slab method.
// Channels: "ray" (sink) takes one ray and one box per word, all coordinates
// signed fixed point with FRACTION_BITS fraction bits; "res" (source) gives one
// word per ray: hit, entry distance (unsigned, saturated with a flag) and the
// entry face. A miss gives an all-zero word.
// Throughput: one word per cycle while the output is not stalled. Each axis
// has its own lane with two pipelined dividers that resolve one quotient bit
// per stage; a ray passes a slab-difference register, COORD_BITS+FRACTION_BITS+3
// divider stages, an ordering register and three merge stages (one per axis,
// the last being the output register).
// Stall: the whole pipeline holds while a result waits and res.ready is low;
// ray.ready is high whenever the output register is empty or being taken.
// Reset clears the valid line only; the pipeline is empty after reset.
module ray_box_slab_test
    import rbst_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    rbst_ray_if.sink    ray,
    rbst_res_if.source  res
);

    localparam int LAT = COORD_BITS + FRACTION_BITS + 8;

    logic [LAT-1:0]       vld_reg;
    logic [LAT-1:0]       vld_next;
    logic                 adv;
    lane_res_t [AXES-1:0] lanes;
    hit_res_t             hres;

    assign adv       = !vld_reg[LAT-1] || res.ready;
    assign ray.ready = adv;
    assign vld_next  = {vld_reg[LAT-2:0], ray.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    rbst_lane #(.CW(COORD_BITS), .FW(FRACTION_BITS)) u_lane_x (
        .clk (clk), .adv (adv), .origin (ray.origin_x), .dir (ray.dir_x),
        .lo (ray.box_lo_x), .hi (ray.box_hi_x), .res (lanes[0])
    );
    rbst_lane #(.CW(COORD_BITS), .FW(FRACTION_BITS)) u_lane_y (
        .clk (clk), .adv (adv), .origin (ray.origin_y), .dir (ray.dir_y),
        .lo (ray.box_lo_y), .hi (ray.box_hi_y), .res (lanes[1])
    );
    rbst_lane #(.CW(COORD_BITS), .FW(FRACTION_BITS)) u_lane_z (
        .clk (clk), .adv (adv), .origin (ray.origin_z), .dir (ray.dir_z),
        .lo (ray.box_lo_z), .hi (ray.box_hi_z), .res (lanes[2])
    );

    rbst_merge u_merge (
        .clk (clk), .adv (adv), .lanes (lanes), .res (hres)
    );

    assign res.valid            = vld_reg[LAT-1];
    assign res.hit              = hres.hit;
    assign res.hit_distance     = hres.distance;
    assign res.distance_clipped = hres.clipped;
    assign res.face_axis        = hres.axis;
    assign res.face_positive    = hres.pos;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> res.hit_distance == '0 && !res.distance_clipped
                                  && res.face_axis == AXIS_X && !res.face_positive)
        else $error("miss word not all zero");

    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.distance_clipped |-> res.hit && (&res.hit_distance))
        else $error("clipped distance not saturated");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.face_axis == AXIS_X || res.face_axis == AXIS_Y
                      || res.face_axis == AXIS_Z)
        else $error("face axis out of range");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !ray.ready)
        else $error("input taken while output stalled");

endmodule

/* dv/ray_box_slab_test_checker.sv */
module ray_box_slab_test_checker
    import rbst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rbst_ray_if   ray,
    rbst_res_if   res,
    output int    errors,
    output int    pending,
    output int    hits_seen,
    output int    clips_seen,
    output int    words_seen
);

    hit_res_t expected_hits[$];

    // floor((num << FRACTION_BITS) / den), den nonzero
    function automatic t_val_t slab_param(input t_val_t num, input t_val_t den);
        t_val_t n;
        t_val_t q;
        t_val_t r;
        begin
            n = num <<< FRACTION_BITS_DEF;
            q = n / den;
            r = n % den;
            if (r != 0 && ((n < 0) != (den < 0)))
                q = q - 1;
            return q;
        end
    endfunction

    function automatic hit_res_t trace_box(input logic [2:0][31:0] o,
                                           input logic [2:0][31:0] d,
                                           input logic [2:0][31:0] lo,
                                           input logic [2:0][31:0] hi);
        hit_res_t   r;
        t_val_t     t_enter;
        t_val_t     t_leave;
        t_val_t     oi, di, loi, hii, t1, t2, tmp;
        logic [1:0] ax;
        logic       pos;
        begin
            r = '0;
            t_enter = T_LOWEST;
            t_leave = T_HIGHEST;
            ax = AXIS_X;
            pos = 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                oi  = t_val_t'($signed(o[i]));
                di  = t_val_t'($signed(d[i]));
                loi = t_val_t'($signed(lo[i]));
                hii = t_val_t'($signed(hi[i]));
                if (di == 0)
                begin
                    if (oi < loi || oi > hii)
                        return '0;
                end
                else
                begin
                    t1 = slab_param(loi - oi, di);
                    t2 = slab_param(hii - oi, di);
                    if (t1 > t2)
                    begin
                        tmp = t1;
                        t1 = t2;
                        t2 = tmp;
                    end
                    if (t1 > t_enter)
                        t_enter = t1;
                    if (t2 < t_leave)
                        t_leave = t2;
                    if (t_enter > t_leave)
                        return '0;
                    // tie goes to the later axis
                    if (t_enter == t1)
                    begin
                        ax = logic'(i) ? 2'(i) : 2'(i);
                        pos = di < 0;
                    end
                end
            end
            if (t_enter < 0)
                return '0;
            r.hit = 1'b1;
            if (t_enter > t_val_t'(64'hFFFF_FFFF))
            begin
                r.distance = '1;
                r.clipped = 1'b1;
            end
            else
                r.distance = t_enter[DIST_BITS-1:0];
            r.axis = ax;
            r.pos = pos;
            return r;
        end
    endfunction

    assign pending = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        hit_res_t want;
        hit_res_t got;
        if (!rst_n)
        begin
            errors <= 0;
            hits_seen <= 0;
            clips_seen <= 0;
            words_seen <= 0;
        end
        else
        begin
            if (ray.valid && ray.ready)
                expected_hits = {expected_hits, trace_box(
                    {ray.origin_z, ray.origin_y, ray.origin_x},
                    {ray.dir_z, ray.dir_y, ray.dir_x},
                    {ray.box_lo_z, ray.box_lo_y, ray.box_lo_x},
                    {ray.box_hi_z, ray.box_hi_y, ray.box_hi_x})};
            if (res.valid && res.ready)
            begin
                got.hit = res.hit;
                got.distance = res.hit_distance;
                got.clipped = res.distance_clipped;
                got.axis = res.face_axis;
                got.pos = res.face_positive;
                words_seen <= words_seen + 1;
                if (expected_hits.size() == 0)
                begin
                    if (errors < 10)
                        $display("checker: unexpected result word hit=%0d dist=%h",
                                 got.hit, got.distance);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    hits_seen <= hits_seen + want.hit;
                    clips_seen <= clips_seen + want.clipped;
                    if (want != got)
                    begin
                        if (errors < 10)
                            $display({"checker: mismatch exp hit=%0d dist=%h clip=%0d axis=%0d ",
                                      "pos=%0d got hit=%0d dist=%h clip=%0d axis=%0d pos=%0d"},
                                     want.hit, want.distance, want.clipped, want.axis, want.pos,
                                     got.hit, got.distance, got.clipped, got.axis, got.pos);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* dv/ray_box_slab_test_tb.sv */
module ray_box_slab_test_tb;
    import rbst_pkg::*;

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   hold_req = 1'b0;
    bit   calm = 1'b0;
    bit   tx_idle = 1'b0;
    int   errors, pending, hits_seen, clips_seen, words_seen;
    int   quiet_cycles = 0;

    rbst_ray_if #(.CW(32)) ray();
    rbst_res_if res();

    ray_box_slab_test DUT (.clk(clk), .rst_n(rst_n), .ray(ray), .res(res));

    ray_box_slab_test_checker chk (
        .clk(clk), .rst_n(rst_n), .ray(ray), .res(res), .errors(errors),
        .pending(pending), .hits_seen(hits_seen), .clips_seen(clips_seen),
        .words_seen(words_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        ray.valid = 1'b0;
        {ray.origin_x, ray.origin_y, ray.origin_z} = '0;
        {ray.dir_x, ray.dir_y, ray.dir_z} = '0;
        {ray.box_lo_x, ray.box_lo_y, ray.box_lo_z} = '0;
        {ray.box_hi_x, ray.box_hi_y, ray.box_hi_z} = '0;
        res.ready = 1'b0;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        repeat (11) @(posedge clk);
        res.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
                res.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((ray.valid && ray.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic offer(input logic [2:0][31:0] o, input logic [2:0][31:0] d,
                         input logic [2:0][31:0] lo, input logic [2:0][31:0] hi);
        begin
            ray.origin_x <= o[0]; ray.origin_y <= o[1]; ray.origin_z <= o[2];
            ray.dir_x <= d[0]; ray.dir_y <= d[1]; ray.dir_z <= d[2];
            ray.box_lo_x <= lo[0]; ray.box_lo_y <= lo[1]; ray.box_lo_z <= lo[2];
            ray.box_hi_x <= hi[0]; ray.box_hi_y <= hi[1]; ray.box_hi_z <= hi[2];
            ray.valid <= 1'b1;
            do
                @(posedge clk);
            while (!ray.ready);
            if (tx_idle && !calm && $urandom_range(0, 7) == 0)
            begin
                ray.valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(0, 400 * 65536)) - 200 * 65536);
    endfunction

    // mostly aimed rays at small boxes, some raw noise and broken aims
    task automatic random_ray();
        logic [2:0][31:0] o, d, lo, hi;
        int kind;
        begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 3; i++)
            begin
                lo[i] = near_coord();
                hi[i] = lo[i] + $urandom_range(1, 50 * 65536);
                o[i] = near_coord();
                d[i] = $signed(lo[i] + hi[i] - 2 * o[i]) >>> $urandom_range(1, 8);
                d[i] = d[i] + $signed($urandom_range(0, 2000)) - 1000;
                if ($urandom_range(0, 11) == 0)
                    d[i] = '0;
                if (kind == 9 && $urandom_range(0, 1) == 1)
                    lo[i] = hi[i] + $urandom_range(0, 65536);
                if (kind <= 1)
                begin
                    o[i] = $urandom; d[i] = $urandom; lo[i] = $urandom; hi[i] = $urandom;
                end
            end
            offer(o, d, lo, hi);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axis hits from both sides
        offer({32'd0, 32'd0, -5 * ONE}, {32'd0, 32'd0, ONE},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        offer({32'd0, 5 * ONE, 32'd0}, {32'd0, -ONE, 32'd0},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        offer({32'd0, 32'd0, 7 * ONE}, {32'd0, 32'd0, -ONE},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        // parallel axis outside slab, all parallel, origin inside
        offer({32'd0, 3 * ONE, -5 * ONE}, {ONE, 32'd0, 32'd0},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        offer({32'd0, 32'd0, 32'd0}, {32'd0, 32'd0, 32'd0},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        offer({32'd0, 32'd0, 32'd0}, {ONE, ONE, ONE},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        // parallel on the slab boundary, diagonal tie, pointing away
        offer({ONE, 32'd0, -4 * ONE}, {32'd0, 32'd0, ONE},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        offer({-3 * ONE, -3 * ONE, -3 * ONE}, {ONE, ONE, ONE},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        offer({-5 * ONE, 32'd0, 32'd0}, {-ONE, 32'd0, 32'd0},
              {-ONE, -ONE, -ONE}, {ONE, ONE, ONE});
        // inverted box, far box with tiny step (clipped distance)
        offer({-5 * ONE, 32'd0, 32'd0}, {ONE, 32'd0, 32'd0},
              {ONE, ONE, ONE}, {-ONE, -ONE, -ONE});
        offer({32'd0, 32'd0, 32'd0}, {32'd1, 32'd1, 32'd1},
              {30000 * ONE, 30000 * ONE, 30000 * ONE}, {SMAX, SMAX, SMAX});
        // extremes of the fields
        offer({SMIN, SMIN, SMIN}, {SMAX, SMAX, SMAX}, {SMAX, SMAX, SMAX},
              {SMAX, SMAX, SMAX});
        offer({SMAX, SMAX, SMAX}, {SMIN, SMIN, SMIN}, {SMIN, SMIN, SMIN},
              {SMAX, SMAX, SMAX});
        offer({SMIN, 32'd0, 32'd0}, {32'd1, SMAX, SMIN}, {SMIN, SMIN, SMIN},
              {SMAX, SMAX, SMAX});
        offer({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, {SMIN, 32'd1, 32'hFFFF_FFFF},
              {SMIN, SMIN, SMIN}, {SMIN, SMIN, SMIN});
        offer({SMIN, SMIN, SMIN}, {32'd1, 32'd1, 32'd1}, {SMAX, SMAX, SMAX},
              {SMAX, SMAX, SMAX});

        tx_idle = 1'b1;
        repeat (450) random_ray();

        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        tx_idle = 1'b0;
        repeat (150) random_ray();
        ray.valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);

        tx_idle = 1'b1;
        repeat (350) random_ray();
        calm = 1'b1;
        repeat (150) random_ray();
        ray.valid <= 1'b0;

        wait (pending == 0);
        repeat (80) @(posedge clk);
        $display("tb: %0d result words checked, %0d hits, %0d clipped distances",
                 words_seen, hits_seen, clips_seen);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
